[src/dpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

  // fixed field widths
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned IN_SAMPLE_W = 12;
  localparam int unsigned OUT_DATA_W  = 12;
  localparam int unsigned MAX_SAMPLE_W = 16;
  localparam int unsigned CHAN_W      = 2;
  localparam int unsigned INDEX_W     = 6;

  // request commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // channel region codes
  localparam logic [CHAN_W-1:0] CHAN_0    = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_1    = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_2    = 2'd2;
  localparam logic [CHAN_W-1:0] CHAN_NONE = 2'd3;

  // bank codes
  localparam logic BANK_A = 1'b0;
  localparam logic BANK_B = 1'b1;

  // request metadata waiting for the memory read data
  typedef struct packed {
    logic              is_read;
    logic              rd_ok;
    logic [CHAN_W-1:0] chan;
    logic              ready_a;
    logic              ready_b;
    logic              bank;
    logic              stored;
  } stage_t;

endpackage

`default_nettype wire

[src/dpc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpc_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read that holds when idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/decimating_pingpong_capture.sv]
// Decimating ping-pong capture of three ADC channels.
// Input channel (in_valid / in_ready): each request is either a sample tick
// (in_command low) carrying three channel samples and the transmitter flag,
// or a read (in_command high) of one stored word by bank, channel and index.
// One tick in every cfg decimation ticks writes all three samples, as one
// wide word, into the bank being filled. A full bank swaps and is marked
// ready when the transmitter waits; otherwise both ready flags clear and the
// same bank refills.
// Result channel (out_valid / out_ready): one result per request, with the
// read word (0 on ticks and on out-of-range reads), both ready flags, the
// saving bank and whether the tick stored a sample set.
// A request passes two register stages, the registered read of the sample
// memory and then the output register.
// Throughput is one request per cycle while out_ready is high; a stage in
// front of the output register absorbs one request, so a stalled receiver
// blocks in_ready only once both are full, and all results hold until taken.
// Reset (rst_n low, synchronous) sets decimation to 1, saves into bank A
// with both ready flags clear; memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module decimating_pingpong_capture #(
  parameter int unsigned PACKAGE_SIZE = 64,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [dpc_pkg::TICK_W-1:0]          cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_command,
  input  wire logic [dpc_pkg::IN_SAMPLE_W-1:0]     in_chan0_sample,
  input  wire logic [dpc_pkg::IN_SAMPLE_W-1:0]     in_chan1_sample,
  input  wire logic [dpc_pkg::IN_SAMPLE_W-1:0]     in_chan2_sample,
  input  wire logic                                in_transmitter_waiting,
  input  wire logic                                in_read_bank,
  input  wire logic [dpc_pkg::CHAN_W-1:0]          in_read_channel,
  input  wire logic [dpc_pkg::INDEX_W-1:0]         in_read_index,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dpc_pkg::OUT_DATA_W-1:0]           out_read_data,
  output logic                                     out_bank_a_ready,
  output logic                                     out_bank_b_ready,
  output logic                                     out_saving_bank,
  output logic                                     out_sample_stored
);

  localparam int unsigned DEPTH  = 2 * PACKAGE_SIZE;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned FW     = $clog2(PACKAGE_SIZE + 1);
  localparam int unsigned WORD_W = 3 * SAMPLE_BITS;

  // control state
  logic [dpc_pkg::TICK_W-1:0] dec_r;
  logic [dpc_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [FW-1:0]              fill_r, fill_nxt;
  logic                       bank_r, bank_nxt;
  logic                       ready_a_r, ready_a_nxt;
  logic                       ready_b_r, ready_b_nxt;

  // pipeline
  dpc_pkg::stage_t            p1_r, p1_nxt;
  logic                       p1_v_r;
  logic                       p1_move;
  logic                       out_v_r;
  logic [dpc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  dpc_pkg::stage_t            out_r;

  logic                       accept;
  logic                       is_tick;
  logic                       full;
  logic [FW-1:0]              fill_a;
  logic [dpc_pkg::TICK_W-1:0] tick_a;
  logic                       store;

  // memory ports
  logic [AW-1:0]              wr_addr;
  logic [WORD_W-1:0]          wr_data;
  logic [AW-1:0]              rd_addr;
  logic [WORD_W-1:0]          rd_data;
  logic [SAMPLE_BITS-1:0]     rd_sel;
  logic [dpc_pkg::MAX_SAMPLE_W-1:0] rd_sel_ext;

  // handshake: the extra stage lets a request in while a result waits
  assign p1_move  = !out_v_r || out_ready;
  assign in_ready = !p1_v_r || p1_move;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (in_command == dpc_pkg::CMD_TICK);

  // tick sequence: bank swap, counter wrap, decimated store
  always_comb begin
    full        = (fill_r == FW'(PACKAGE_SIZE));
    bank_nxt    = bank_r;
    ready_a_nxt = ready_a_r;
    ready_b_nxt = ready_b_r;
    fill_a      = fill_r;
    if (full) begin
      fill_a = '0;
      if (in_transmitter_waiting) begin
        bank_nxt = !bank_r;
        if (bank_r == dpc_pkg::BANK_A) begin
          ready_a_nxt = 1'b1;
        end else begin
          ready_b_nxt = 1'b1;
        end
      end else begin
        ready_a_nxt = 1'b0;
        ready_b_nxt = 1'b0;
      end
    end
    tick_a   = (tick_r == dec_r) ? '0 : tick_r;
    store    = (dec_r != '0) && (tick_a == dec_r - 1'b1);
    fill_nxt = fill_a + FW'(store);
    tick_nxt = tick_a + 1'b1;
  end

  // state update on accepted ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r     <= 16'd1;
      tick_r    <= '0;
      fill_r    <= '0;
      bank_r    <= dpc_pkg::BANK_A;
      ready_a_r <= 1'b0;
      ready_b_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dec_r <= cfg_wr_data;
      end
      if (accept && is_tick) begin
        tick_r    <= tick_nxt;
        fill_r    <= fill_nxt;
        bank_r    <= bank_nxt;
        ready_a_r <= ready_a_nxt;
        ready_b_r <= ready_b_nxt;
      end
    end
  end

  // memory addressing: one wide word per position holds all three channels
  assign wr_addr = AW'(32'(bank_nxt) * PACKAGE_SIZE + 32'(fill_a));
  assign wr_data = {SAMPLE_BITS'(dpc_pkg::MAX_SAMPLE_W'(in_chan2_sample)),
                    SAMPLE_BITS'(dpc_pkg::MAX_SAMPLE_W'(in_chan1_sample)),
                    SAMPLE_BITS'(dpc_pkg::MAX_SAMPLE_W'(in_chan0_sample))};
  assign rd_addr = AW'(32'(in_read_bank) * PACKAGE_SIZE + 32'(in_read_index));

  dpc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && is_tick && store),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept && !is_tick),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // metadata for the request entering the read stage
  always_comb begin
    p1_nxt.is_read = !is_tick;
    p1_nxt.rd_ok   = (in_read_channel != dpc_pkg::CHAN_NONE)
                     && (32'(in_read_index) < PACKAGE_SIZE);
    p1_nxt.chan    = in_read_channel;
    p1_nxt.ready_a = is_tick ? ready_a_nxt : ready_a_r;
    p1_nxt.ready_b = is_tick ? ready_b_nxt : ready_b_r;
    p1_nxt.bank    = is_tick ? bank_nxt : bank_r;
    p1_nxt.stored  = is_tick && store;
  end

  // read stage valid and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (in_ready) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r <= p1_nxt;
    end
  end

  // channel select out of the wide memory word
  always_comb begin
    unique case (p1_r.chan)
      dpc_pkg::CHAN_0: rd_sel = rd_data[SAMPLE_BITS-1:0];
      dpc_pkg::CHAN_1: rd_sel = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      dpc_pkg::CHAN_2: rd_sel = rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      default:         rd_sel = '0;
    endcase
    rd_sel_ext   = dpc_pkg::MAX_SAMPLE_W'(rd_sel);
    out_data_nxt = (p1_r.is_read && p1_r.rd_ok)
                   ? rd_sel_ext[dpc_pkg::OUT_DATA_W-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (p1_move) begin
      out_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move && p1_v_r) begin
      out_r      <= p1_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_read_data     = out_data_r;
  assign out_bank_a_ready  = out_r.ready_a;
  assign out_bank_b_ready  = out_r.ready_b;
  assign out_saving_bank   = out_r.bank;
  assign out_sample_stored = out_r.stored;

`ifndef SYNTHESIS
  // fill position never runs past one package
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= PACKAGE_SIZE)
    else $error("fill position past package size");

  // a stored tick leaves a nonzero fill position
  a_store_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_tick && store |=> fill_r != '0)
    else $error("store did not advance fill position");

  // saving bank changes only on a full bank tick
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && is_tick && full) |=> $stable(bank_r))
    else $error("bank changed without full bank");

  // read stage holds its request while the output stalls
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r && !p1_move |=> p1_v_r && $stable(p1_r) && $stable(rd_data))
    else $error("read stage lost its request under stall");
`endif

endmodule

`default_nettype wire
